[src/stlw_pkg.sv]
package stlw_pkg;

	localparam int MaxWordsW = 16;
	localparam int WordW     = 32;
	localparam int KindW     = 2;
	localparam int PaddrW    = 3;
	localparam int PdataW    = 32;

	localparam logic [KindW-1:0] KIND_CHAR = 2'd0;
	localparam logic [KindW-1:0] KIND_NUM  = 2'd1;
	localparam logic [KindW-1:0] KIND_WORD = 2'd2;

	localparam logic [7:0] CH_QUOTE  = 8'h27;
	localparam logic [7:0] CH_SEMI   = 8'h3B;
	localparam logic [7:0] CH_NL     = 8'h0A;
	localparam logic [7:0] CH_X      = 8'h78;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_N      = 8'h6E;
	localparam logic [7:0] CH_T      = 8'h74;
	localparam logic [7:0] CH_R      = 8'h72;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_SPACE  = 8'h20;

	localparam logic [15:0] MAX_WORDS_RESET = 16'hFFFF;

	typedef enum logic [3:0] {
		M_IDLE      = 4'd0,
		M_NUM       = 4'd1,
		M_CH_FIRST  = 4'd2,
		M_CH_ESC    = 4'd3,
		M_HEX_HI    = 4'd4,
		M_HEX_LO    = 4'd5,
		M_CH_SKIP   = 4'd6,
		M_WORD      = 4'd7,
		M_WORD_SKIP = 4'd8,
		M_COMMENT   = 4'd9
	} lex_mode_t;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       end_of_input;
	} byte_item_t;

	typedef struct packed {
		logic [WordW-1:0] word;
		logic [KindW-1:0] token_kind;
	} word_item_t;

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= 8'h30) && (c <= 8'h39);
	endfunction

	function automatic logic is_upper(input logic [7:0] c);
		return (c >= 8'h41) && (c <= 8'h5A);
	endfunction

	function automatic logic is_letter(input logic [7:0] c);
		return is_upper(c) || ((c >= 8'h61) && (c <= 8'h7A));
	endfunction

	function automatic logic [7:0] to_lower(input logic [7:0] c);
		return is_upper(c) ? (c + 8'd32) : c;
	endfunction

	function automatic logic [3:0] hex_value(input logic [7:0] c);
		logic [3:0] v;
		v = 4'd0;
		if (is_digit(c)) begin
			v = c[3:0];
		end else if (((c >= 8'h61) && (c <= 8'h66)) || ((c >= 8'h41) && (c <= 8'h46))) begin
			v = c[3:0] + 4'd9;
		end
		return v;
	endfunction

	function automatic logic [7:0] escape_value(input logic [7:0] c);
		logic [7:0] v;
		case (c)
			CH_BSLASH: v = CH_BSLASH;
			CH_N:      v = CH_NL;
			CH_T:      v = CH_TAB;
			CH_QUOTE:  v = CH_QUOTE;
			CH_R:      v = CH_CR;
			default:   v = 8'd0;
		endcase
		return v;
	endfunction

	function automatic logic [WordW-1:0] padded_word(input logic [WordW-1:0] w,
			input logic [1:0] n);
		logic [WordW-1:0] p;
		case (n)
			2'd0:    p = {4{CH_SPACE}};
			2'd1:    p = {w[7:0], {3{CH_SPACE}}};
			2'd2:    p = {w[15:0], {2{CH_SPACE}}};
			default: p = {w[23:0], CH_SPACE};
		endcase
		return p;
	endfunction

	function automatic lex_mode_t start_mode(input logic [7:0] c);
		lex_mode_t m;
		if (c == CH_QUOTE) begin
			m = M_CH_FIRST;
		end else if (is_digit(c)) begin
			m = M_NUM;
		end else if (is_letter(c)) begin
			m = M_WORD;
		end else if (c == CH_SEMI) begin
			m = M_COMMENT;
		end else begin
			m = M_IDLE;
		end
		return m;
	endfunction

endpackage

[src/source_token_to_word_lexer_top.sv]
// channel   direction  handshake               payload
// byte      in         byte_valid/byte_ready   byte_data  (in_byte, end_of_input)
// word      out        word_valid/word_ready   word_data  (word, token_kind)
// config    in         APB psel/penable/pready paddr, pwdata, prdata (max_words at 0)
//
// One byte per cycle while the word output is not stalled: a byte is held in the input
// register, where the lexer state machine and accumulator update, and its word (if any)
// is registered from there into the output register.
// Reset clears mode, counters and valids; max_words returns to 65535.
// A stalled word holds the output register; the input register then holds too and
// byte_ready drops, so at most two bytes are in flight.
module source_token_to_word_lexer_top import stlw_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                byte_valid,
	output logic                byte_ready,
	input  byte_item_t          byte_data,
	output logic                word_valid,
	input  logic                word_ready,
	output word_item_t          word_data,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [PaddrW-1:0]   paddr,
	input  logic [PdataW-1:0]   pwdata,
	output logic [PdataW-1:0]   prdata,
	output logic                pready
);

	logic [MaxWordsW-1:0] max_words_q;
	logic                 v_s1;
	byte_item_t           item_s1;
	logic                 out_v_q;
	word_item_t           out_q;

	lex_mode_t            mode_q, mode_d;
	logic [WordW-1:0]     acc_q, acc_d;
	logic [WordW-1:0]     wbytes_q, wbytes_d;
	logic [1:0]           letters_q, letters_d;
	logic [3:0]           hn_q, hn_d;
	logic [MaxWordsW-1:0] words_q;

	logic                 emit_req;
	logic                 ended_number;
	logic [WordW-1:0]     emit_word;
	logic [KindW-1:0]     emit_kind;
	logic                 fire;
	logic                 advance;
	logic [7:0]           c;
	logic                 eoi;
	logic [WordW-1:0]     wshift;

	assign pready = 1'b1;
	assign prdata = paddr[2] ? '0 : {{(PdataW-MaxWordsW){1'b0}}, max_words_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_words_q <= MAX_WORDS_RESET;
		end else if (psel && penable && pwrite && !paddr[2]) begin
			max_words_q <= pwdata[MaxWordsW-1:0];
		end
	end

	assign c       = item_s1.in_byte;
	assign eoi     = item_s1.end_of_input;
	assign advance = v_s1 && (!out_v_q || word_ready);
	assign byte_ready = !v_s1 || advance;
	assign wshift  = {wbytes_q[23:0], to_lower(c)};

	always_comb begin
		mode_d = mode_q;
		unique case (mode_q)
			M_NUM: begin
				if (!is_digit(c)) begin
					mode_d = start_mode(c);
				end
			end
			M_CH_FIRST: begin
				if (c == CH_BSLASH) begin
					mode_d = M_CH_ESC;
				end else begin
					mode_d = (c == CH_QUOTE) ? M_IDLE : M_CH_SKIP;
				end
			end
			M_CH_ESC:  mode_d = (c == CH_X) ? M_HEX_HI : M_CH_SKIP;
			M_HEX_HI:  mode_d = M_HEX_LO;
			M_HEX_LO:  mode_d = M_CH_SKIP;
			M_CH_SKIP: begin
				if (c == CH_QUOTE) begin
					mode_d = M_IDLE;
				end
			end
			M_WORD: begin
				if (c == CH_NL) begin
					mode_d = M_IDLE;
				end else if (letters_q == 2'd3) begin
					mode_d = M_WORD_SKIP;
				end
			end
			M_WORD_SKIP: begin
				if (!is_letter(c)) begin
					mode_d = start_mode(c);
				end
			end
			M_COMMENT: begin
				if (c == CH_NL) begin
					mode_d = M_IDLE;
				end
			end
			default: mode_d = start_mode(c);
		endcase
	end

	always_comb begin
		acc_d        = acc_q;
		wbytes_d     = wbytes_q;
		letters_d    = letters_q;
		hn_d         = hn_q;
		emit_req     = 1'b0;
		ended_number = 1'b0;
		emit_word    = '0;
		emit_kind    = KIND_CHAR;
		unique case (mode_q)
			M_NUM: begin
				if (is_digit(c)) begin
					acc_d = (acc_q << 3) + (acc_q << 1) + {{(WordW-4){1'b0}}, c[3:0]};
				end else begin
					emit_req     = 1'b1;
					ended_number = 1'b1;
					emit_word    = acc_q;
					emit_kind    = KIND_NUM;
				end
			end
			M_CH_FIRST: begin
				if (c != CH_BSLASH) begin
					emit_req  = 1'b1;
					emit_word = {{(WordW-8){1'b0}}, c};
				end
			end
			M_CH_ESC: begin
				if (c != CH_X) begin
					emit_req  = 1'b1;
					emit_word = {{(WordW-8){1'b0}}, escape_value(c)};
				end
			end
			M_HEX_HI: hn_d = hex_value(c);
			M_HEX_LO: begin
				emit_req  = 1'b1;
				emit_word = {{(WordW-8){1'b0}}, hn_q, hex_value(c)};
			end
			M_CH_SKIP, M_COMMENT: begin
			end
			M_WORD: begin
				if (c == CH_NL) begin
					emit_req  = 1'b1;
					emit_word = padded_word(wbytes_q, letters_q);
					emit_kind = KIND_WORD;
				end else begin
					wbytes_d = wshift;
					if (letters_q == 2'd3) begin
						emit_req  = 1'b1;
						emit_word = wshift;
						emit_kind = KIND_WORD;
					end else begin
						letters_d = letters_q + 2'd1;
					end
				end
			end
			default: begin
			end
		endcase

		// load a fresh token wherever one starts on this byte
		if (mode_d != mode_q || mode_q == M_IDLE || mode_q > M_COMMENT) begin
			if (mode_d == M_NUM) begin
				acc_d = {{(WordW-4){1'b0}}, c[3:0]};
			end else if (mode_d == M_WORD && mode_q != M_WORD) begin
				wbytes_d  = {{(WordW-8){1'b0}}, to_lower(c)};
				letters_d = 2'd1;
			end
		end

		// flush the pending token on the final byte
		if (eoi && !emit_req && !ended_number) begin
			case (mode_d) inside
				M_NUM: begin
					emit_req  = 1'b1;
					emit_word = acc_d;
					emit_kind = KIND_NUM;
				end
				M_CH_FIRST, M_CH_ESC, M_HEX_HI: begin
					emit_req  = 1'b1;
					emit_word = '0;
					emit_kind = KIND_CHAR;
				end
				M_HEX_LO: begin
					emit_req  = 1'b1;
					emit_word = {{(WordW-8){1'b0}}, hn_d, 4'd0};
					emit_kind = KIND_CHAR;
				end
				M_WORD: begin
					emit_req  = 1'b1;
					emit_word = padded_word(wbytes_d, letters_d);
					emit_kind = KIND_WORD;
				end
				default: begin
				end
			endcase
		end
	end

	assign fire = emit_req && (words_q < max_words_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (byte_ready) begin
			v_s1 <= byte_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_ready && byte_valid) begin
			item_s1 <= byte_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= M_IDLE;
			acc_q     <= '0;
			wbytes_q  <= '0;
			letters_q <= '0;
			hn_q      <= '0;
			words_q   <= '0;
		end else if (advance) begin
			if (eoi) begin
				mode_q    <= M_IDLE;
				acc_q     <= '0;
				wbytes_q  <= '0;
				letters_q <= '0;
				hn_q      <= '0;
				words_q   <= '0;
			end else begin
				mode_q    <= mode_d;
				acc_q     <= acc_d;
				wbytes_q  <= wbytes_d;
				letters_q <= letters_d;
				hn_q      <= hn_d;
				words_q   <= words_q + {{(MaxWordsW-1){1'b0}}, fire};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (advance && fire) begin
			out_v_q <= 1'b1;
		end else if (word_ready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && fire) begin
			out_q.word       <= emit_word;
			out_q.token_kind <= emit_kind;
		end
	end

	assign word_valid = out_v_q;
	assign word_data  = out_q;

endmodule
